FILE: hw/rtl/refcounted_slot_binder_core_assert.svh
// Assertion macros used by the checker module of the slot binder.
`ifndef REFCOUNTED_SLOT_BINDER_CORE_ASSERT_SVH
`define REFCOUNTED_SLOT_BINDER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, muted while rst_n is low.
`define RSB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, muted while rst_n is low.
`define RSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rsb_pkg.sv
// Shared types and codes of the slot binder.
package rsb_pkg;

    localparam int KEY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int IN_W    = 40;    // command + key, padded to whole bytes
    localparam int RCNT_W  = 16;    // ref_count field on the result stream

    typedef enum logic [1:0] {
        CMD_BIND        = 2'd0,
        CMD_RELEASE     = 2'd1,
        CMD_RELEASE_ALL = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_EXISTING  = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_HELD      = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_INVALID   = 3'd6,
        ST_SATURATED = 3'd7
    } status_t;

    // Table read address source
    typedef enum logic [1:0] {
        RD_SCAN = 2'd0,
        RD_LAST = 2'd1,
        RD_USED = 2'd2
    } rd_sel_t;

    // Table write operation
    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_UPD   = 3'd1,
        WR_MOVE  = 3'd2,
        WR_CLEAR = 3'd3,
        WR_NEW   = 3'd4
    } wr_op_t;

    // Where location / count of a result come from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_HIT  = 2'd1,
        SRC_FREE = 2'd2,
        SRC_NEW  = 2'd3
    } res_src_t;

    typedef struct packed {
        logic     load_req;
        rd_sel_t  rd_sel;
        logic     scan_next;
        logic     cap_hit;
        logic     cap_last;
        wr_op_t   wr_op;
        logic     used_inc;
        logic     used_dec;
        logic     res_load;
        status_t  res_status;
        res_src_t res_src;
        logic     out_load;
    } ctl_t;

    typedef struct packed {
        logic key_zero;
        logic cmd_bind;
        logic cmd_release;
        logic cmd_release_all;
        logic scan_done;
        logic key_match;
        logic count_max;
        logic count_gt1;
        logic table_full;
        logic hit_is_last;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/refcounted_slot_binder_core.sv
// A zero key or unknown command is answered without a search. Otherwise the used slots
// are searched from the first; a bind miss then writes a new slot, a hit counts up on bind
// (unless saturated) or down on a held release, and freeing a slot other than the last used
// one first moves the last used slot into it. Requests are handled one at a time; the search
// reads the slots one after another from the single read port of the slot table, and the next
// request may start while a result waits. Reset (rst_n, async, low): table empty, labels 1..SLOTS.
module refcounted_slot_binder_core
    import rsb_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int LW    = $clog2(SLOTS + 1),
    localparam int OUT_W = ((3 + LW + RCNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // request stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // command[1:0], key[33:2], zero pad
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // status[2:0], location, ref_count[15:0], pad
);

    // The controller and datapath talk only through these two bundles.
    ctl_t ctl;
    sts_t sts;

    // Controller: one-hot sequencer. Accepts a request only in its idle state;
    // the result sits in the datapath's output register so the next request
    // can start while the consumer stalls.
    rsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Datapath: slot table (key, count, label per slot) in one RAM with a
    // valid bit per slot; a slot never written reads as key 0, count 0 and
    // its own index plus one as label. Used slots stay packed at the front:
    // a freed slot takes the last used slot's contents and its own label
    // moves to the last position.
    rsb_datapath #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

FILE: hw/rtl/rsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/rsb_datapath.sv
// Slot table, counters, hit/last holding registers and result registers.
module rsb_datapath
    import rsb_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int LW    = $clog2(SLOTS + 1),
    localparam int EW    = KEY_W + COUNT_WIDTH + LW,
    localparam int OUT_W = ((3 + LW + RCNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  in_data,
    output logic [OUT_W-1:0] out_data,
    output logic             out_valid,
    input  logic             out_ready,
    input  ctl_t             ctl,
    output sts_t             sts
);

    // request
    logic [CMD_W-1:0]       cmd_reg;
    logic [KEY_W-1:0]       key_reg;

    logic [LW-1:0]          used_reg;
    logic [LW-1:0]          scan_reg;
    logic [SLOTS-1:0]       valid_reg;

    // read side
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          rd_addr_reg;
    logic                   rd_vld_reg;
    logic [EW-1:0]          ram_q;
    logic [EW-1:0]          entry;
    logic [KEY_W-1:0]       ent_key;
    logic [LW-1:0]          ent_lbl;
    logic [LW-1:0]          last_idx;

    // hit and last slot
    logic [AW-1:0]          hit_idx_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg;
    logic [LW-1:0]          hit_lbl_reg;
    logic [KEY_W-1:0]       last_key_reg;
    logic [COUNT_WIDTH-1:0] last_cnt_reg;
    logic [LW-1:0]          last_lbl_reg;
    logic [COUNT_WIDTH-1:0] new_cnt;

    // write side
    logic                   we;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    // result
    logic [2:0]             res_status_reg;
    logic [LW-1:0]          res_loc_reg;
    logic [COUNT_WIDTH-1:0] res_cnt_reg;
    logic [31:0]            res_cnt_wide;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_valid_reg;

    assign last_idx = used_reg - LW'(1);

    always_comb
    begin
        case (ctl.rd_sel)
            RD_LAST: rd_addr = last_idx[AW-1:0];
            RD_USED: rd_addr = used_reg[AW-1:0];
            default: rd_addr = scan_reg[AW-1:0];
        endcase
    end

    // never-written entries read as their reset contents
    assign entry = rd_vld_reg ? ram_q
                              : {{KEY_W{1'b0}}, {COUNT_WIDTH{1'b0}},
                                 LW'(rd_addr_reg) + LW'(1)};
    assign ent_key = entry[EW-1 -: KEY_W];
    assign ent_lbl = entry[LW-1:0];

    always_comb
    begin
        new_cnt = hit_cnt_reg;
        if (cmd_reg == CMD_BIND && !sts.count_max)
        begin
            new_cnt = hit_cnt_reg + COUNT_WIDTH'(1);
        end
        else if (cmd_reg == CMD_RELEASE && sts.count_gt1)
        begin
            new_cnt = hit_cnt_reg - COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        we      = 1'b1;
        wr_addr = hit_idx_reg;
        wr_data = {key_reg, new_cnt, hit_lbl_reg};
        case (ctl.wr_op)
            WR_UPD:   ;
            WR_MOVE:  wr_data = {last_key_reg, last_cnt_reg, last_lbl_reg};
            WR_CLEAR:
            begin
                wr_addr = last_idx[AW-1:0];
                wr_data = {{KEY_W{1'b0}}, {COUNT_WIDTH{1'b0}}, hit_lbl_reg};
            end
            WR_NEW:
            begin
                wr_addr = used_reg[AW-1:0];
                wr_data = {key_reg, COUNT_WIDTH'(1), ent_lbl};
            end
            default:  we = 1'b0;
        endcase
    end

    rsb_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            scan_reg      <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= valid_reg[rd_addr];
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.used_inc)
            begin
                used_reg <= used_reg + LW'(1);
            end
            else if (ctl.used_dec)
            begin
                used_reg <= last_idx;
            end
            if (ctl.load_req)
            begin
                scan_reg <= '0;
            end
            else if (ctl.scan_next)
            begin
                scan_reg <= scan_reg + LW'(1);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_cnt_wide = 32'(res_cnt_reg);

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        if (ctl.load_req)
        begin
            cmd_reg <= in_data[CMD_W-1:0];
            key_reg <= in_data[CMD_W +: KEY_W];
        end
        if (ctl.cap_hit)
        begin
            hit_idx_reg <= scan_reg[AW-1:0];
            hit_cnt_reg <= entry[LW +: COUNT_WIDTH];
            hit_lbl_reg <= ent_lbl;
        end
        if (ctl.cap_last)
        begin
            last_key_reg <= ent_key;
            last_cnt_reg <= entry[LW +: COUNT_WIDTH];
            last_lbl_reg <= ent_lbl;
        end
        if (ctl.res_load)
        begin
            res_status_reg <= ctl.res_status;
            case (ctl.res_src)
                SRC_HIT:
                begin
                    res_loc_reg <= hit_lbl_reg;
                    res_cnt_reg <= new_cnt;
                end
                SRC_FREE:
                begin
                    res_loc_reg <= hit_lbl_reg;
                    res_cnt_reg <= '0;
                end
                SRC_NEW:
                begin
                    res_loc_reg <= ent_lbl;
                    res_cnt_reg <= COUNT_WIDTH'(1);
                end
                default:
                begin
                    res_loc_reg <= '0;
                    res_cnt_reg <= '0;
                end
            endcase
        end
        if (ctl.out_load)
        begin
            out_data_reg <= OUT_W'({res_cnt_wide[RCNT_W-1:0], res_loc_reg, res_status_reg});
        end
    end

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

    assign sts.key_zero        = (key_reg == '0);
    assign sts.cmd_bind        = (cmd_reg == CMD_BIND);
    assign sts.cmd_release     = (cmd_reg == CMD_RELEASE);
    assign sts.cmd_release_all = (cmd_reg == CMD_RELEASE_ALL);
    assign sts.scan_done       = (scan_reg == used_reg);
    assign sts.key_match       = (ent_key == key_reg);
    assign sts.count_max       = (hit_cnt_reg == {COUNT_WIDTH{1'b1}});
    assign sts.count_gt1       = (hit_cnt_reg > COUNT_WIDTH'(1));
    assign sts.table_full      = (used_reg == LW'(SLOTS));
    assign sts.hit_is_last     = (hit_idx_reg == last_idx[AW-1:0]);
    assign sts.out_free        = !out_valid_reg || out_ready;

endmodule

FILE: hw/rtl/rsb_ctrl.sv
// Sequencer for search, update, free/swap and bind of one request.
module rsb_ctrl
    import rsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_CHECK     = 11'b000_0000_0010,
        S_SRCH_RD   = 11'b000_0000_0100,
        S_SRCH_CMP  = 11'b000_0000_1000,
        S_DECIDE    = 11'b000_0001_0000,
        S_LAST_WAIT = 11'b000_0010_0000,
        S_FREE_MOVE = 11'b000_0100_0000,
        S_FREE_CLR  = 11'b000_1000_0000,
        S_NEW_RD    = 11'b001_0000_0000,
        S_NEW_WR    = 11'b010_0000_0000,
        S_RESULT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.rd_sel     = RD_SCAN;
        ctl.wr_op      = WR_NONE;
        ctl.res_status = ST_NOT_FOUND;
        ctl.res_src    = SRC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.key_zero)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_INVALID;
                    state_next     = S_RESULT;
                end
                else if (!(sts.cmd_bind || sts.cmd_release || sts.cmd_release_all))
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (!sts.scan_done)
                begin
                    state_next = S_SRCH_CMP;
                end
                else if (sts.cmd_bind && !sts.table_full)
                begin
                    state_next = S_NEW_RD;
                end
                else
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = sts.cmd_bind ? ST_FULL : ST_NOT_FOUND;
                    state_next     = S_RESULT;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.key_match)
                begin
                    ctl.cap_hit = 1'b1;
                    state_next  = S_DECIDE;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_DECIDE:
            begin
                if (sts.cmd_bind)
                begin
                    ctl.wr_op      = sts.count_max ? WR_NONE : WR_UPD;
                    ctl.res_load   = 1'b1;
                    ctl.res_status = sts.count_max ? ST_SATURATED : ST_EXISTING;
                    ctl.res_src    = SRC_HIT;
                    state_next     = S_RESULT;
                end
                else if (sts.cmd_release && sts.count_gt1)
                begin
                    ctl.wr_op      = WR_UPD;
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_HELD;
                    ctl.res_src    = SRC_HIT;
                    state_next     = S_RESULT;
                end
                else if (sts.hit_is_last)
                begin
                    state_next = S_FREE_CLR;
                end
                else
                begin
                    ctl.rd_sel = RD_LAST;
                    state_next = S_LAST_WAIT;
                end
            end
            S_LAST_WAIT:
            begin
                ctl.cap_last = 1'b1;
                state_next   = S_FREE_MOVE;
            end
            S_FREE_MOVE:
            begin
                ctl.wr_op  = WR_MOVE;
                state_next = S_FREE_CLR;
            end
            S_FREE_CLR:
            begin
                ctl.wr_op      = WR_CLEAR;
                ctl.used_dec   = 1'b1;
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_FREED;
                ctl.res_src    = SRC_FREE;
                state_next     = S_RESULT;
            end
            S_NEW_RD:
            begin
                ctl.rd_sel = RD_USED;
                state_next = S_NEW_WR;
            end
            S_NEW_WR:
            begin
                ctl.wr_op      = WR_NEW;
                ctl.used_inc   = 1'b1;
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_NEW;
                ctl.res_src    = SRC_NEW;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/rsb_checker.sv
// Port-level checker for the slot binder, bound to the top level.
`include "refcounted_slot_binder_core_assert.svh"

module rsb_checker
    import rsb_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int LW    = $clog2(SLOTS + 1),
    localparam int OUT_W = ((3 + LW + RCNT_W + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [2:0]        st;
    logic [LW-1:0]     loc;
    logic [RCNT_W-1:0] cnt;

    assign st  = m_axis_tdata[2:0];
    assign loc = m_axis_tdata[3 +: LW];
    assign cnt = m_axis_tdata[3 + LW +: RCNT_W];

    // one request in flight: no accept right after an accept
    `RSB_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request accepted while previous one still in work")

    // stalled result holds
    `RSB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

    // rejections carry no slot
    `RSB_ASSERT_NOW(a_reject_empty,
        m_axis_tvalid && (st == ST_FULL || st == ST_NOT_FOUND || st == ST_INVALID),
        loc == '0 && cnt == '0, "rejected request reports a slot")

    // new bind: count one, real label
    `RSB_ASSERT_NOW(a_new_bind, m_axis_tvalid && st == ST_NEW,
        cnt == RCNT_W'(1) && loc != '0 && loc <= LW'(SLOTS), "bad new bind result")

    // freed: label kept, count zero
    `RSB_ASSERT_NOW(a_freed, m_axis_tvalid && st == ST_FREED,
        cnt == '0 && loc != '0, "bad free result")

endmodule

bind refcounted_slot_binder_core rsb_checker #(
    .SLOTS (SLOTS)
) u_rsb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
